>>> src/gme_pkg.sv
// Shared types, codes and constants for the gene mutation engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gme_pkg;

  localparam int DEF_MAX_LENGTH  = 256;
  localparam int DEF_SYMBOL_BITS = 8;
  localparam int TAP_GROUP       = 16;

  localparam int GENE_LEN_W = 9;
  localparam int THRESH_W   = 16;
  localparam int POS_W      = 8;
  localparam int SYM_IN_W   = 8;
  localparam int DRAW_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [GENE_LEN_W-1:0] GENE_LEN_RESET = GENE_LEN_W'(100);
  localparam logic [THRESH_W-1:0]   THRESH_RESET   = '0;

  localparam logic [CFG_IDX_W-1:0] REG_GENE_LENGTH      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MUTATE_THRESHOLD = 1'b1;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_READ   = 2'd1,
    MODE_MUTATE = 2'd2,
    MODE_UNUSED = 2'd3
  } gme_mode_e;

  typedef enum logic [1:0] {
    METH_REPLACE = 2'd0,
    METH_INSERT  = 2'd1,
    METH_DELETE  = 2'd2,
    METH_ROTATE  = 2'd3
  } gme_method_e;

  typedef enum logic [2:0] {
    K_HOLD    = 3'd0,
    K_WRITE   = 3'd1,
    K_INS_FWD = 3'd2,
    K_INS_BWD = 3'd3,
    K_DEL_FWD = 3'd4,
    K_DEL_BWD = 3'd5,
    K_ROT_FWD = 3'd6,
    K_ROT_BWD = 3'd7
  } gme_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_APPLY = 2'd1,
    ST_OUT   = 2'd2
  } gme_state_e;

  typedef struct packed {
    logic      en;
    gme_kind_e kind;
  } gme_ctl_t;

  typedef struct packed {
    logic [2:0]          pad;
    logic                direction;
    logic [1:0]          method;
    logic [DRAW_W-1:0]   trigger_draw;
    logic [SYM_IN_W-1:0] symbol;
    logic [POS_W-1:0]    position;
    logic [1:0]          mode;
  } gme_in_beat_t;

  typedef struct packed {
    logic [5:0]          pad;
    logic                error;
    logic                applied;
    logic [SYM_IN_W-1:0] read_value;
  } gme_out_beat_t;

endpackage

`default_nettype wire

>>> src/gene_mutation_engine.sv
// Top level of the gene mutation engine: stream ports, configuration
// registers, control sequencer. Uses gme_pkg, gme_cell and gme_tap.
//
//   Channel   Direction  Handshake              Payload
//   s_axis    in         tvalid / tready        tdata: command beat
//   m_axis    out        tvalid / tready        tdata: result beat
//   cfg       in         cfg_we_i, no stall     cfg_idx_i, cfg_wdata_i
//
// Each beat passes through these steps in order: accepting it and loading the
// read-out group registers, updating the cell chain and registering the
// result, and handing the result over, which lasts until it is taken.
// The chain updates all cells in one step, so the time per beat does not
// depend on position or length.
// Reset sets the length to 100 and the threshold to zero; symbol contents
// are undefined until written and get no clearing pass.
// A stalled result blocks the input until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module gene_mutation_engine #(
  parameter int MAX_LENGTH  = gme_pkg::DEF_MAX_LENGTH,
  parameter int SYMBOL_BITS = gme_pkg::DEF_SYMBOL_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // mode[1:0], position[9:2], symbol[17:10], trigger_draw[33:18],
  // method[35:34], direction[36], zero[39:37]
  input  wire logic [gme_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // read_value[7:0], applied[8], error[9], zero[15:10]
  output logic      [gme_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [gme_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [gme_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import gme_pkg::*;

  localparam int LEN_W = $clog2(MAX_LENGTH + 1);
  localparam int CW    = (LEN_W > GENE_LEN_W) ? LEN_W : GENE_LEN_W;

  gme_state_e state_q, state_d;

  logic [GENE_LEN_W-1:0] gene_len_q;
  logic [THRESH_W-1:0]   thresh_q;

  gme_in_beat_t  beat;
  gme_out_beat_t res_q, res_d;

  logic                   accept;
  logic [CW-1:0]          pos_x, glen_x, eff_len, last_x, rd_idx;
  logic                   err, hit;
  gme_kind_e              kind;
  logic                   rd_sel;
  logic [SYMBOL_BITS+SYM_IN_W-1:0] sym_wide, rd_wide;
  logic [SYMBOL_BITS-1:0] sym_in;

  gme_kind_e              kind_q;
  logic [CW-1:0]          pos_q, last_q;
  logic [SYMBOL_BITS-1:0] sym_q;
  logic                   rd_q, applied_q, error_q;

  gme_ctl_t               ctl;
  logic [SYMBOL_BITS-1:0] values [MAX_LENGTH];
  logic [SYMBOL_BITS-1:0] tap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gene_len_q <= GENE_LEN_RESET;
      thresh_q   <= THRESH_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_GENE_LENGTH) begin
        gene_len_q <= cfg_wdata_i[GENE_LEN_W-1:0];
      end else if (cfg_idx_i == REG_MUTATE_THRESHOLD) begin
        thresh_q <= cfg_wdata_i[THRESH_W-1:0];
      end
    end
  end

  assign beat     = gme_in_beat_t'(s_axis_tdata_i);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign pos_x    = CW'(beat.position);
  assign glen_x   = CW'(gene_len_q);
  assign eff_len  = (glen_x > CW'(MAX_LENGTH)) ? CW'(MAX_LENGTH) : glen_x;
  assign last_x   = eff_len - CW'(1);
  assign err      = (gme_mode_e'(beat.mode) != MODE_UNUSED) && (pos_x >= eff_len);
  assign hit      = beat.trigger_draw < thresh_q;
  assign sym_wide = {{SYMBOL_BITS{1'b0}}, beat.symbol};
  assign sym_in   = sym_wide[SYMBOL_BITS-1:0];

  always_comb begin
    kind   = K_HOLD;
    rd_sel = 1'b0;
    if (!err) begin
      unique case (gme_mode_e'(beat.mode))
        MODE_WRITE:  kind = K_WRITE;
        MODE_READ:   rd_sel = 1'b1;
        MODE_MUTATE: begin
          if (hit) begin
            unique case (gme_method_e'(beat.method))
              METH_REPLACE: kind = K_WRITE;
              METH_INSERT:  kind = beat.direction ? K_INS_FWD : K_INS_BWD;
              METH_DELETE:  kind = beat.direction ? K_DEL_FWD : K_DEL_BWD;
              METH_ROTATE:  kind = beat.direction ? K_ROT_FWD : K_ROT_BWD;
              default:      kind = K_HOLD;
            endcase
          end
        end
        MODE_UNUSED: kind = K_HOLD;
        default:     kind = K_HOLD;
      endcase
    end
  end

  always_comb begin
    unique case (kind)
      K_ROT_FWD: rd_idx = last_x;
      K_ROT_BWD: rd_idx = '0;
      default:   rd_idx = pos_x;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= K_HOLD;
      rd_q      <= 1'b0;
      applied_q <= 1'b0;
      error_q   <= 1'b0;
    end else if (accept) begin
      kind_q    <= kind;
      rd_q      <= rd_sel;
      applied_q <= !err && (gme_mode_e'(beat.mode) == MODE_MUTATE) && hit;
      error_q   <= err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q  <= pos_x;
      last_q <= last_x;
      sym_q  <= sym_in;
    end
  end

  gme_tap #(
    .MAX_LENGTH  (MAX_LENGTH),
    .SYMBOL_BITS (SYMBOL_BITS),
    .CW          (CW)
  ) u_tap (
    .clk_i    (clk_i),
    .load_i   (accept),
    .idx_i    (rd_idx),
    .values_i (values),
    .tap_o    (tap)
  );

  assign ctl.en   = (state_q == ST_APPLY);
  assign ctl.kind = kind_q;

  for (genvar i = 0; i < MAX_LENGTH; i++) begin : g_cell
    logic [SYMBOL_BITS-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = values[i-1];
    end
    if (i == MAX_LENGTH - 1) begin : g_end
      assign right = '0;
    end else begin : g_right
      assign right = values[i+1];
    end

    gme_cell #(
      .IDX         (i),
      .CW          (CW),
      .SYMBOL_BITS (SYMBOL_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .pos_i   (pos_q),
      .last_i  (last_q),
      .sym_i   (sym_q),
      .left_i  (left),
      .right_i (right),
      .wrap_i  (tap),
      .value_o (values[i])
    );
  end

  assign rd_wide = {{SYM_IN_W{1'b0}}, tap};

  always_comb begin
    res_d            = '0;
    res_d.read_value = rd_q ? rd_wide[SYM_IN_W-1:0] : '0;
    res_d.applied    = applied_q;
    res_d.error      = error_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_APPLY) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) state_d = ST_APPLY;
      end
      ST_APPLY: state_d = ST_OUT;
      ST_OUT: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tdata_o = res_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("input ready while a result is pending");

  a_accept_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_APPLY))
    else $error("accepted beat did not move to the update step");

  a_err_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(res_q.error && res_q.applied))
    else $error("result flags both error and applied");

  a_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (res_q.read_value != '0)) |-> (!res_q.error && !res_q.applied))
    else $error("nonzero read value on a beat that was not a read");

endmodule

`default_nettype wire

>>> src/gme_cell.sv
// One cell of the symbol chain: holds one symbol and takes its next value
// from itself, a neighbor, the new symbol or the wrap tap. Uses gme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gme_cell #(
  parameter int IDX         = 0,
  parameter int CW          = 9,
  parameter int SYMBOL_BITS = gme_pkg::DEF_SYMBOL_BITS
) (
  input  wire logic                   clk_i,
  input  wire gme_pkg::gme_ctl_t      ctl_i,
  input  wire logic [CW-1:0]          pos_i,
  input  wire logic [CW-1:0]          last_i,
  input  wire logic [SYMBOL_BITS-1:0] sym_i,
  input  wire logic [SYMBOL_BITS-1:0] left_i,
  input  wire logic [SYMBOL_BITS-1:0] right_i,
  input  wire logic [SYMBOL_BITS-1:0] wrap_i,
  output logic      [SYMBOL_BITS-1:0] value_o
);
  import gme_pkg::*;

  localparam logic [CW-1:0] ME = CW'(IDX);

  logic [SYMBOL_BITS-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (ctl_i.en) begin
      unique case (ctl_i.kind)
        K_HOLD:    value_d = value_q;
        K_WRITE:   if (ME == pos_i) value_d = sym_i;
        K_INS_FWD: begin
          if (ME == pos_i) value_d = sym_i;
          else if (ME > pos_i && ME <= last_i) value_d = left_i;
        end
        K_INS_BWD: begin
          if (ME == pos_i) value_d = sym_i;
          else if (ME < pos_i) value_d = right_i;
        end
        K_DEL_FWD: begin
          if (ME == '0) value_d = sym_i;
          else if (ME <= pos_i) value_d = left_i;
        end
        K_DEL_BWD: begin
          if (ME == last_i) value_d = sym_i;
          else if (ME >= pos_i && ME < last_i) value_d = right_i;
        end
        K_ROT_FWD: begin
          if (ME == '0) value_d = wrap_i;
          else if (ME <= last_i) value_d = left_i;
        end
        K_ROT_BWD: begin
          if (ME == last_i) value_d = wrap_i;
          else if (ME < last_i) value_d = right_i;
        end
        default:   value_d = value_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

>>> src/gme_tap.sv
// Read-out tree for the cell chain: selects one cell, ORs it into group
// registers, and merges the groups into one tap. Uses gme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gme_tap #(
  parameter int MAX_LENGTH  = gme_pkg::DEF_MAX_LENGTH,
  parameter int SYMBOL_BITS = gme_pkg::DEF_SYMBOL_BITS,
  parameter int CW          = 9
) (
  input  wire logic                   clk_i,
  input  wire logic                   load_i,
  input  wire logic [CW-1:0]          idx_i,
  input  wire logic [SYMBOL_BITS-1:0] values_i [MAX_LENGTH],
  output logic      [SYMBOL_BITS-1:0] tap_o
);
  import gme_pkg::*;

  localparam int NGRP = (MAX_LENGTH + TAP_GROUP - 1) / TAP_GROUP;
  localparam int NPAD = NGRP * TAP_GROUP;

  logic [SYMBOL_BITS-1:0] masked [NPAD];
  logic [SYMBOL_BITS-1:0] grp_d  [NGRP];
  logic [SYMBOL_BITS-1:0] grp_q  [NGRP];

  for (genvar k = 0; k < NPAD; k++) begin : g_mask
    if (k < MAX_LENGTH) begin : g_real
      assign masked[k] = (idx_i == CW'(k)) ? values_i[k] : '0;
    end else begin : g_pad
      assign masked[k] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < TAP_GROUP; j++) begin
        grp_d[g] = grp_d[g] | masked[g*TAP_GROUP + j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    tap_o = '0;
    for (int g = 0; g < NGRP; g++) begin
      tap_o = tap_o | grp_q[g];
    end
  end

endmodule

`default_nettype wire
